// ===== sv/assert_macros.svh =====
// assertion helpers, compiled out when SYNTH is defined
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
`define ASSERT_CLK(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("assertion failed");
`define ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define ASSERT_CLK(lbl, prop)
`define ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

// ===== sv/crw_pkg.sv =====
package crw_pkg;

  localparam int COORD_BITS_DEF = 24;
  localparam int STEP_BITS_DEF  = 40;

  localparam int DIR_BITS       = 3;
  localparam int HEIGHT_BITS    = 23;
  localparam int RSQ_BITS       = 48;
  localparam int HIT_H_BITS     = 24;
  localparam int LIMIT_BITS     = 40;
  localparam int BIN_W_BITS     = 16;
  localparam int TIME_BITS      = 40;
  localparam int COUNT_BITS     = 32;
  localparam int CFG_DATA_BITS  = 48;
  localparam int CFG_INDEX_BITS = 3;

  localparam logic [RSQ_BITS-1:0]   RSQ_MAX           = '1;
  localparam logic [LIMIT_BITS-1:0] STEPS_TO_MISS_RST = 40'd1000000;
  localparam logic [BIN_W_BITS-1:0] STEPS_PER_BIN_RST = 16'd1;

  // direction codes, anything above DIR_Z_NEG is ignored
  localparam logic [DIR_BITS-1:0] DIR_X_POS = 3'd0;
  localparam logic [DIR_BITS-1:0] DIR_X_NEG = 3'd1;
  localparam logic [DIR_BITS-1:0] DIR_Y_POS = 3'd2;
  localparam logic [DIR_BITS-1:0] DIR_Y_NEG = 3'd3;
  localparam logic [DIR_BITS-1:0] DIR_Z_POS = 3'd4;
  localparam logic [DIR_BITS-1:0] DIR_Z_NEG = 3'd5;

  localparam logic [CFG_INDEX_BITS-1:0] REG_CAP_HEIGHT     = 3'd0;
  localparam logic [CFG_INDEX_BITS-1:0] REG_CAP_RADIUS_SQ  = 3'd1;
  localparam logic [CFG_INDEX_BITS-1:0] REG_CHAN_RADIUS_SQ = 3'd2;
  localparam logic [CFG_INDEX_BITS-1:0] REG_START_HEIGHT   = 3'd3;
  localparam logic [CFG_INDEX_BITS-1:0] REG_HIT_HEIGHT     = 3'd4;
  localparam logic [CFG_INDEX_BITS-1:0] REG_STEPS_TO_MISS  = 3'd5;
  localparam logic [CFG_INDEX_BITS-1:0] REG_STEPS_PER_BIN  = 3'd6;

  typedef struct packed {
    logic        [HEIGHT_BITS-1:0] cap_height;
    logic        [RSQ_BITS-1:0]    cap_radius_sq;
    logic        [RSQ_BITS-1:0]    channel_radius_sq;
    logic        [HEIGHT_BITS-1:0] start_height;
    logic signed [HIT_H_BITS-1:0]  hit_height;
    logic        [LIMIT_BITS-1:0]  steps_to_miss;
    logic        [BIN_W_BITS-1:0]  steps_per_bin;
  } cfg_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL,
    ST_MOVE,
    ST_EVAL,
    ST_DIV,
    ST_EMIT
  } state_t;

  typedef struct packed {
    logic load;
    logic mul;
    logic move;
    logic eval;
    logic div_start;
    logic emit;
  } cmd_t;

  typedef struct packed {
    logic ignored;
    logic hit;
    logic miss;
    logic div_done;
    logic out_free;
  } status_t;

endpackage

// ===== sv/crw_move_if.sv =====
interface crw_move_if;
  logic                          valid;
  logic                          ready;
  logic [crw_pkg::DIR_BITS-1:0]  direction;

  modport source (output valid, output direction, input ready);
  modport sink (input valid, input direction, output ready);
endinterface

// ===== sv/crw_result_if.sv =====
interface crw_result_if;
  logic                           valid;
  logic                           ready;
  logic                           hit;
  logic [crw_pkg::TIME_BITS-1:0]  time_bin;
  logic [crw_pkg::COUNT_BITS-1:0] hits_total;
  logic [crw_pkg::COUNT_BITS-1:0] misses_total;

  modport source (output valid, output hit, output time_bin, output hits_total,
                  output misses_total, input ready);
  modport sink (input valid, input hit, input time_bin, input hits_total,
                input misses_total, output ready);
endinterface

// ===== sv/crw_div.sv =====
module crw_div #(
  parameter int STEP_BITS = crw_pkg::STEP_BITS_DEF
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             start,
  input  logic [STEP_BITS-1:0]             dividend,
  input  logic [crw_pkg::BIN_W_BITS-1:0]   divisor,
  output logic                             done,
  output logic [STEP_BITS-1:0]             quotient
);

  localparam int CNT_BITS = $clog2(STEP_BITS + 1);
  localparam int BW       = crw_pkg::BIN_W_BITS;

  logic [CNT_BITS-1:0] count;
  logic [BW-1:0]       rem;
  logic [BW-1:0]       dsr;
  logic [BW:0]         rem_sh;
  logic [BW:0]         diff;
  logic                ge;

  // restoring divide, one quotient bit a cycle
  always_comb begin
    rem_sh = {rem, quotient[STEP_BITS-1]};
    diff   = rem_sh - {1'b0, dsr};
    ge     = rem_sh >= {1'b0, dsr};
    done   = count == CNT_BITS'(1);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (start) begin
      count <= CNT_BITS'(STEP_BITS);
    end else if (count != '0) begin
      count <= count - CNT_BITS'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quotient <= dividend;
      rem      <= '0;
      dsr      <= divisor;
    end else if (count != '0) begin
      rem      <= ge ? diff[BW-1:0] : rem_sh[BW-1:0];
      quotient <= {quotient[STEP_BITS-2:0], ge};
    end
  end

endmodule

// ===== sv/crw_ctrl.sv =====
module crw_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  crw_pkg::status_t   status,
  output crw_pkg::cmd_t      cmd
);

  crw_pkg::state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= crw_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    in_ready   = 1'b0;
    unique case (state)
      crw_pkg::ST_IDLE: begin
        in_ready = !rst;
        if (in_valid && !rst) begin
          cmd.load = 1'b1;
          if (!status.ignored) begin
            state_next = crw_pkg::ST_MUL;
          end
        end
      end
      crw_pkg::ST_MUL: begin
        cmd.mul    = 1'b1;
        state_next = crw_pkg::ST_MOVE;
      end
      crw_pkg::ST_MOVE: begin
        cmd.move   = 1'b1;
        state_next = crw_pkg::ST_EVAL;
      end
      crw_pkg::ST_EVAL: begin
        cmd.eval = 1'b1;
        priority if (status.hit) begin
          cmd.div_start = 1'b1;
          state_next    = crw_pkg::ST_DIV;
        end else if (status.miss) begin
          state_next = crw_pkg::ST_EMIT;
        end else begin
          state_next = crw_pkg::ST_IDLE;
        end
      end
      crw_pkg::ST_DIV: begin
        if (status.div_done) begin
          state_next = crw_pkg::ST_EMIT;
        end
      end
      crw_pkg::ST_EMIT: begin
        if (status.out_free) begin
          cmd.emit   = 1'b1;
          state_next = crw_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = crw_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

// ===== sv/crw_dp.sv =====
module crw_dp #(
  parameter int COORD_BITS = crw_pkg::COORD_BITS_DEF,
  parameter int STEP_BITS  = crw_pkg::STEP_BITS_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  input  crw_pkg::cfg_t                     cfg,
  input  logic [crw_pkg::DIR_BITS-1:0]      direction,
  input  crw_pkg::cmd_t                     cmd,
  output crw_pkg::status_t                  status,
  input  logic                              res_ready,
  output logic                              res_valid,
  output logic                              res_hit,
  output logic [crw_pkg::TIME_BITS-1:0]     res_time_bin,
  output logic [crw_pkg::COUNT_BITS-1:0]    res_hits_total,
  output logic [crw_pkg::COUNT_BITS-1:0]    res_misses_total
);

  localparam int MAG_BITS = COORD_BITS - 1;
  localparam int SQ_BITS  = 2 * MAG_BITS;
  localparam int SUM_BITS = (SQ_BITS + 1 > crw_pkg::RSQ_BITS) ? SQ_BITS + 1
                                                              : crw_pkg::RSQ_BITS + 1;
  localparam int CMP_BITS = (COORD_BITS + 1 > crw_pkg::HIT_H_BITS) ? COORD_BITS + 1
                                                                   : crw_pkg::HIT_H_BITS;
  localparam int LIM_BITS = (STEP_BITS + 1 > crw_pkg::LIMIT_BITS) ? STEP_BITS + 1
                                                                  : crw_pkg::LIMIT_BITS;
  localparam int RB       = crw_pkg::RSQ_BITS;
  localparam int CB       = crw_pkg::COUNT_BITS;

  localparam logic signed [COORD_BITS:0] CMAX  = {2'b00, {MAG_BITS{1'b1}}};
  localparam logic signed [COORD_BITS:0] CMIN  = -CMAX;
  localparam logic signed [COORD_BITS:0] C_ONE = {{COORD_BITS{1'b0}}, 1'b1};

  function automatic logic signed [COORD_BITS-1:0] sat(input logic signed [COORD_BITS:0] v);
    logic signed [COORD_BITS:0] r;
    r = v;
    if (v > CMAX) begin
      r = CMAX;
    end else if (v < CMIN) begin
      r = CMIN;
    end
    return r[COORD_BITS-1:0];
  endfunction

  // walk state
  logic signed [COORD_BITS-1:0] pos_x, pos_y, pos_z;
  logic        [RB-1:0]         radius_sq;
  logic        [STEP_BITS-1:0]  step_index;
  logic        [CB-1:0]         hit_count, miss_count;

  // per-request working registers
  logic        [crw_pkg::DIR_BITS-1:0] dir;
  logic signed [COORD_BITS-1:0]        nx, ny;
  logic        [SQ_BITS-1:0]           sq_x, sq_y;
  logic                                res_is_hit;

  logic signed [COORD_BITS-1:0] nx_next, ny_next;
  logic signed [COORD_BITS:0]   px_w, py_w, pz_w, t_w;
  logic        [COORD_BITS-1:0] ax_full, ay_full;
  logic        [MAG_BITS-1:0]   ax, ay;
  logic        [SUM_BITS-1:0]   sum;
  logic        [RB-1:0]         nr;
  logic signed [CMP_BITS-1:0]   z_cmp, t_cmp, cap_cmp, hit_cmp, start_cmp, cmax_cmp;
  logic signed [COORD_BITS-1:0] start_z;
  logic                         low, blocked, lateral, floor_stop, cap_stop, in_chan;
  logic        [LIM_BITS-1:0]   next_count;
  logic        [crw_pkg::BIN_W_BITS-1:0] bin_w;
  logic                         div_done;
  logic        [STEP_BITS-1:0]  quotient;

  always_comb begin
    px_w = {pos_x[COORD_BITS-1], pos_x};
    py_w = {pos_y[COORD_BITS-1], pos_y};
    pz_w = {pos_z[COORD_BITS-1], pos_z};
    nx_next = pos_x;
    ny_next = pos_y;
    unique case (direction)
      crw_pkg::DIR_X_POS: nx_next = sat(px_w + C_ONE);
      crw_pkg::DIR_X_NEG: nx_next = sat(px_w - C_ONE);
      crw_pkg::DIR_Y_POS: ny_next = sat(py_w + C_ONE);
      crw_pkg::DIR_Y_NEG: ny_next = sat(py_w - C_ONE);
      default: begin
      end
    endcase

    ax_full = nx[COORD_BITS-1] ? -nx : nx;
    ay_full = ny[COORD_BITS-1] ? -ny : ny;
    ax      = ax_full[MAG_BITS-1:0];
    ay      = ay_full[MAG_BITS-1:0];

    sum = SUM_BITS'(sq_x) + SUM_BITS'(sq_y);
    nr  = (sum > SUM_BITS'(crw_pkg::RSQ_MAX)) ? crw_pkg::RSQ_MAX : sum[RB-1:0];

    z_cmp     = CMP_BITS'(pos_z);
    t_w       = pz_w - C_ONE;
    t_cmp     = CMP_BITS'(t_w);
    cap_cmp   = CMP_BITS'(cfg.cap_height);
    hit_cmp   = CMP_BITS'(cfg.hit_height);
    start_cmp = CMP_BITS'(cfg.start_height);
    cmax_cmp  = CMP_BITS'(CMAX);
    start_z   = (start_cmp > cmax_cmp) ? CMAX[COORD_BITS-1:0] : start_cmp[COORD_BITS-1:0];

    lateral = dir <= crw_pkg::DIR_Y_NEG;
    low     = z_cmp <= cap_cmp;
    blocked = low && ((radius_sq <= cfg.channel_radius_sq && nr > cfg.channel_radius_sq) ||
                      (radius_sq >= cfg.cap_radius_sq && nr < cfg.cap_radius_sq));
    floor_stop = radius_sq >= cfg.cap_radius_sq && t_w[COORD_BITS];
    cap_stop   = radius_sq < cfg.cap_radius_sq && radius_sq > cfg.channel_radius_sq &&
                 t_cmp < cap_cmp;

    in_chan    = radius_sq <= cfg.channel_radius_sq;
    next_count = LIM_BITS'(step_index) + LIM_BITS'(1);
    bin_w      = (cfg.steps_per_bin == '0) ? crw_pkg::BIN_W_BITS'(1) : cfg.steps_per_bin;

    status.ignored  = direction > crw_pkg::DIR_Z_NEG;
    status.hit      = in_chan && z_cmp <= hit_cmp;
    status.miss     = (&step_index) || next_count >= LIM_BITS'(cfg.steps_to_miss);
    status.div_done = div_done;
    status.out_free = !res_valid || res_ready;
  end

  crw_div #(
    .STEP_BITS (STEP_BITS)
  ) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (cmd.div_start),
    .dividend (step_index),
    .divisor  (bin_w),
    .done     (div_done),
    .quotient (quotient)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      pos_x      <= '0;
      pos_y      <= '0;
      pos_z      <= '0;
      radius_sq  <= '0;
      step_index <= '0;
      hit_count  <= '0;
      miss_count <= '0;
      res_valid  <= 1'b0;
    end else begin
      if (cmd.move) begin
        if (lateral) begin
          if (!blocked) begin
            pos_x     <= nx;
            pos_y     <= ny;
            radius_sq <= nr;
          end
        end else if (dir == crw_pkg::DIR_Z_POS) begin
          pos_z <= sat(pz_w + C_ONE);
        end else if (!(floor_stop || cap_stop)) begin
          pos_z <= sat(t_w);
        end
      end
      if (cmd.eval && !status.hit && !status.miss) begin
        step_index <= step_index + STEP_BITS'(1);
      end
      if (cmd.emit) begin
        pos_x      <= '0;
        pos_y      <= '0;
        pos_z      <= start_z;
        radius_sq  <= '0;
        step_index <= '0;
        if (res_is_hit) begin
          hit_count <= hit_count + CB'(1);
        end else begin
          miss_count <= miss_count + CB'(1);
        end
        res_valid <= 1'b1;
      end else if (res_ready) begin
        res_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      dir <= direction;
      nx  <= nx_next;
      ny  <= ny_next;
    end
    if (cmd.mul) begin
      sq_x <= ax * ax;
      sq_y <= ay * ay;
    end
    if (cmd.eval) begin
      res_is_hit <= status.hit;
    end
    if (cmd.emit) begin
      res_hit          <= res_is_hit;
      res_time_bin     <= res_is_hit ? crw_pkg::TIME_BITS'(quotient) : '0;
      res_hits_total   <= res_is_hit ? hit_count + CB'(1) : hit_count;
      res_misses_total <= res_is_hit ? miss_count : miss_count + CB'(1);
    end
  end

endmodule

// ===== sv/channel_capture_random_walk.sv =====
// lattice random walk near a capped pore
// moves: one 3-bit direction per request (x+, x-, y+, y-, z+, z-; the two
//   remaining codes are accepted and change nothing)
// results: one request per finished walk, captured or timed out, with the
//   time bin and running hit and miss totals
// wr_en/wr_index/wr_data: register writes, only while the walk is idle (the user's duty; not enforced)
// a step runs through the accept, square, move and check states in turn
// a capture adds the bit-serial time bin divide, then the load of the
//   result register; a timeout adds the load only
// the result register lets the next step be taken while a result waits; a
//   walk that ends while it is still full holds until the receiver takes it
// reset: registers to their defaults, molecule at (0, 0, 0), totals zero
module channel_capture_random_walk #(
  parameter int COORD_BITS = crw_pkg::COORD_BITS_DEF,
  parameter int STEP_BITS  = crw_pkg::STEP_BITS_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 wr_en,
  input  logic [crw_pkg::CFG_INDEX_BITS-1:0]   wr_index,
  input  logic [crw_pkg::CFG_DATA_BITS-1:0]    wr_data,
  crw_move_if.sink                             moves,
  crw_result_if.source                         results
);

`include "assert_macros.svh"

  crw_pkg::cfg_t    cfg;
  crw_pkg::cmd_t    cmd;
  crw_pkg::status_t status;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.cap_height        <= '0;
      cfg.cap_radius_sq     <= '0;
      cfg.channel_radius_sq <= '0;
      cfg.start_height      <= '0;
      cfg.hit_height        <= '0;
      cfg.steps_to_miss     <= crw_pkg::STEPS_TO_MISS_RST;
      cfg.steps_per_bin     <= crw_pkg::STEPS_PER_BIN_RST;
    end else if (wr_en) begin
      unique case (wr_index)
        crw_pkg::REG_CAP_HEIGHT:
          cfg.cap_height <= wr_data[crw_pkg::HEIGHT_BITS-1:0];
        crw_pkg::REG_CAP_RADIUS_SQ:
          cfg.cap_radius_sq <= wr_data[crw_pkg::RSQ_BITS-1:0];
        crw_pkg::REG_CHAN_RADIUS_SQ:
          cfg.channel_radius_sq <= wr_data[crw_pkg::RSQ_BITS-1:0];
        crw_pkg::REG_START_HEIGHT:
          cfg.start_height <= wr_data[crw_pkg::HEIGHT_BITS-1:0];
        crw_pkg::REG_HIT_HEIGHT:
          cfg.hit_height <= signed'(wr_data[crw_pkg::HIT_H_BITS-1:0]);
        crw_pkg::REG_STEPS_TO_MISS:
          cfg.steps_to_miss <= wr_data[crw_pkg::LIMIT_BITS-1:0];
        crw_pkg::REG_STEPS_PER_BIN:
          cfg.steps_per_bin <= wr_data[crw_pkg::BIN_W_BITS-1:0];
        default: begin
        end
      endcase
    end
  end

  crw_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (moves.valid),
    .in_ready (moves.ready),
    .status   (status),
    .cmd      (cmd)
  );

  crw_dp #(
    .COORD_BITS (COORD_BITS),
    .STEP_BITS  (STEP_BITS)
  ) u_dp (
    .clk              (clk),
    .rst              (rst),
    .cfg              (cfg),
    .direction        (moves.direction),
    .cmd              (cmd),
    .status           (status),
    .res_ready        (results.ready),
    .res_valid        (results.valid),
    .res_hit          (results.hit),
    .res_time_bin     (results.time_bin),
    .res_hits_total   (results.hits_total),
    .res_misses_total (results.misses_total)
  );

  `ASSERT_CLK(a_ready_only_idle, moves.ready |-> !(cmd.mul || cmd.move || cmd.eval || cmd.emit))
  `ASSERT_NEXT(a_mul_then_move, cmd.mul, cmd.move)
  `ASSERT_CLK(a_emit_when_free, cmd.emit |-> (!results.valid || results.ready))
  `ASSERT_NEXT(a_emit_shows, cmd.emit, results.valid)
  `ASSERT_CLK(a_miss_zero_bin, (results.valid && !results.hit) |-> (results.time_bin == '0))

endmodule
